// File: design/kntc_pkg.sv
// ----------------------------------------------------------------------------
// kntc_pkg
// Shared types and constants for the k-nomial tree child lister.
// ----------------------------------------------------------------------------
package kntc_pkg;

  localparam int RANK_W   = 12;
  localparam int K_W      = 5;
  localparam int NODES_W  = 13;
  localparam int WIDE_W   = 18;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 7;
  localparam int PROD_W   = WIDE_W + K_W;

  localparam logic [K_W-1:0]   K_MIN      = 5'd2;
  localparam logic [K_W-1:0]   K_MAX      = 5'd16;
  localparam logic [K_W-1:0]   K_RESET    = 5'd10;
  localparam logic [NODES_W-1:0] NODES_RESET = 13'd1;
  localparam logic [CNT_W-1:0] RESULT_CAP = 7'd64;

  localparam logic CFG_BRANCH = 1'b0;
  localparam logic CFG_NODES  = 1'b1;

  typedef struct packed {
    logic [RANK_W-1:0]  parent;
    logic [K_W-1:0]     k;
    logic [NODES_W-1:0] nodes;
    logic [WIDE_W-1:0]  delta;
  } job_t;

endpackage

// File: design/kntc_front.sv
// ----------------------------------------------------------------------------
// kntc_front
// Accepts a parent rank, clamps the configuration and searches delta.
// ----------------------------------------------------------------------------
module kntc_front #(
  parameter int MAX_NODES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kntc_pkg::RANK_W-1:0]   in_parent_rank,
  input  logic [kntc_pkg::K_W-1:0]      radix,
  input  logic [kntc_pkg::NODES_W-1:0]  node_count,
  output logic                          q_push,
  output kntc_pkg::job_t                q_data,
  input  logic                          q_full
);
  import kntc_pkg::*;

  localparam logic FS_IDLE   = 1'b0;
  localparam logic FS_SEARCH = 1'b1;
  localparam logic [WIDE_W-1:0] MAX_N = WIDE_W'(MAX_NODES);

  logic                 state_r, state_nxt;
  job_t                 job_r, job_nxt;
  logic [K_W-1:0]       k_clamp;
  logic [NODES_W-1:0]   nodes_clamp;
  logic [PROD_W-1:0]    prod;

  always_comb begin
    if (radix < K_MIN) begin
      k_clamp = K_MIN;
    end else if (radix > K_MAX) begin
      k_clamp = K_MAX;
    end else begin
      k_clamp = radix;
    end
    if (WIDE_W'(node_count) > MAX_N) begin
      nodes_clamp = MAX_N[NODES_W-1:0];
    end else begin
      nodes_clamp = node_count;
    end
  end

  assign prod     = job_r.delta * job_r.k;
  assign in_stall = (state_r != FS_IDLE);
  assign q_data   = job_r;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    q_push    = 1'b0;
    unique case (state_r)
      FS_IDLE: begin
        if (in_valid) begin
          job_nxt.parent = in_parent_rank;
          job_nxt.k      = k_clamp;
          job_nxt.nodes  = nodes_clamp;
          job_nxt.delta  = WIDE_W'(1);
          state_nxt      = FS_SEARCH;
        end
      end
      FS_SEARCH: begin
        if (job_r.delta <= WIDE_W'(job_r.parent)) begin
          job_nxt.delta = prod[WIDE_W-1:0];
        end else if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = FS_IDLE;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    job_r <= job_nxt;
  end

endmodule

// File: design/kntc_queue.sv
// ----------------------------------------------------------------------------
// kntc_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module kntc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  kntc_pkg::job_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output kntc_pkg::job_t  pop_data
);
  import kntc_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/kntc_back.sv
// ----------------------------------------------------------------------------
// kntc_back
// Walks the candidate children of one job and drives the result register.
// ----------------------------------------------------------------------------
module kntc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_not_empty,
  input  kntc_pkg::job_t               q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [kntc_pkg::RANK_W-1:0]  out_child_rank,
  output logic                         out_has_child,
  output logic                         out_last
);
  import kntc_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [K_W-1:0]       k_r, k_nxt;
  logic [NODES_W-1:0]   nodes_r, nodes_nxt;
  logic [WIDE_W-1:0]    cand_r, cand_nxt;
  logic [WIDE_W-1:0]    delta_r, delta_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [RANK_W-1:0]    held_r, held_nxt;
  logic                 ov_r, ov_nxt;
  logic [RANK_W-1:0]    oc_r, oc_nxt;
  logic                 oh_r, oh_nxt;
  logic                 ol_r, ol_nxt;
  logic                 out_free, in_range, group_end;
  logic [PROD_W-1:0]    prod;

  assign out_free  = !ov_r || !out_stall;
  assign in_range  = (cand_r < WIDE_W'(nodes_r)) && (cnt_r != RESULT_CAP);
  assign group_end = (K_W'(idx_r) == k_r - K_W'(1));
  assign prod      = delta_r * k_r;

  assign out_valid      = ov_r;
  assign out_child_rank = oc_r;
  assign out_has_child  = oh_r;
  assign out_last       = ol_r;

  always_comb begin
    busy_nxt  = busy_r;
    k_nxt     = k_r;
    nodes_nxt = nodes_r;
    cand_nxt  = cand_r;
    delta_nxt = delta_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    held_nxt  = held_r;
    ov_nxt    = ov_r && out_stall;
    oc_nxt    = oc_r;
    oh_nxt    = oh_r;
    ol_nxt    = ol_r;
    q_pop     = 1'b0;
    if (!busy_r) begin
      if (q_not_empty) begin
        q_pop     = 1'b1;
        busy_nxt  = 1'b1;
        k_nxt     = q_data.k;
        nodes_nxt = q_data.nodes;
        delta_nxt = q_data.delta;
        cand_nxt  = WIDE_W'(q_data.parent) + q_data.delta;
        idx_nxt   = IDX_W'(1);
        cnt_nxt   = '0;
      end
    end else if (out_free) begin
      if (cnt_r != '0 || !in_range) begin
        ov_nxt = 1'b1;
        oc_nxt = (cnt_r != '0) ? held_r : '0;
        oh_nxt = (cnt_r != '0);
        ol_nxt = !in_range;
      end
      if (in_range) begin
        held_nxt = cand_r[RANK_W-1:0];
        cnt_nxt  = cnt_r + CNT_W'(1);
        cand_nxt = cand_r + delta_r;
        if (group_end) begin
          idx_nxt   = IDX_W'(1);
          delta_nxt = prod[WIDE_W-1:0];
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    k_r     <= k_nxt;
    nodes_r <= nodes_nxt;
    cand_r  <= cand_nxt;
    delta_r <= delta_nxt;
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    held_r  <= held_nxt;
    oc_r    <= oc_nxt;
    oh_r    <= oh_nxt;
    ol_r    <= ol_nxt;
  end

endmodule

// File: design/k_nomial_tree_children_core.sv
// ----------------------------------------------------------------------------
// k_nomial_tree_children_core
// Lists the children of one parent rank in a k-nomial broadcast tree.
// ----------------------------------------------------------------------------
//  port group  | direction | handshake          | payload
//  in_*        | input     | in_valid/in_stall  | in_parent_rank
//  out_*       | output    | out_valid/out_stall| out_child_rank, out_has_child,
//              |           |                    | out_last
//  cfg_*       | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  Front: takes no new word until the delta search multiply loop for the
//  current word is done and its job is queued.
//  Back: one child per cycle while the result is not stalled.
//  A two-entry job queue lets the front search while the back emits.
//  Reset is synchronous, active low; it empties the queue and the result
//  register and restores branch factor 10 and node count 1.
//  A stalled result holds the back; the front runs on until the queue fills.
// ----------------------------------------------------------------------------
module k_nomial_tree_children_core #(
  parameter int MAX_NODES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kntc_pkg::RANK_W-1:0]   in_parent_rank,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kntc_pkg::RANK_W-1:0]   out_child_rank,
  output logic                          out_has_child,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [kntc_pkg::NODES_W-1:0]  cfg_data
);
  import kntc_pkg::*;

  logic [K_W-1:0]     branch_r, branch_nxt;
  logic [NODES_W-1:0] nodes_r, nodes_nxt;
  logic               q_push, q_full, q_pop, q_not_empty;
  job_t               q_in, q_out;

  assign cfg_ready = 1'b1;

  always_comb begin
    branch_nxt = branch_r;
    nodes_nxt  = nodes_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BRANCH: branch_nxt = cfg_data[K_W-1:0];
        CFG_NODES:  nodes_nxt  = cfg_data;
        default:    branch_nxt = branch_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      branch_r <= K_RESET;
      nodes_r  <= NODES_RESET;
    end else begin
      branch_r <= branch_nxt;
      nodes_r  <= nodes_nxt;
    end
  end

  kntc_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_parent_rank (in_parent_rank),
    .radix          (branch_r),
    .node_count     (nodes_r),
    .q_push         (q_push),
    .q_data         (q_in),
    .q_full         (q_full)
  );

  kntc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  kntc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_data         (q_out),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_child_rank (out_child_rank),
    .out_has_child  (out_has_child),
    .out_last       (out_last)
  );

`ifndef SYNTH
  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_child |-> out_last && (out_child_rank == '0))
    else $error("empty-list marker without last or with a rank");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("front accepted a word without starting the search");

  a_quiet_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result presented right after reset");
`endif

endmodule
